// File: rtl/core/eca_pkg.sv
package eca_pkg;

   localparam int TIME_W    = 18;
   localparam int STEP_W    = 17;
   localparam int VAL_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;

   typedef logic signed [TIME_W-1:0] time_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic [VAL_W-1:0]         csr_data_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic signed [MUL_W-1:0]  mul_op_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef enum logic [1:0] {REQ_RESTART, REQ_ADVANCE, REQ_SET, REQ_HOLD} req_kind_type;
   typedef enum logic [2:0] {
      CURVE_LINEAR, CURVE_QUAD, CURVE_CUBIC, CURVE_QUART,
      CURVE_QUINT, CURVE_SINE, CURVE_EXPO, CURVE_CIRC
   } curve_kind_type;
   typedef enum logic [1:0] {LOOP_CLAMP, LOOP_REWIND, LOOP_PINGPONG, LOOP_ODD} loop_kind_type;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURVE, CSR_LOOP, CSR_DIR, CSR_START, CSR_END, CSR_SCALE, CSR_SHIFT
   } csr_reg_type;

   typedef struct packed {
      logic [32:0] magic;
      logic [5:0]  shift;
   } div_type;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [31:0] LN2_Q30 = 32'd744261118;
   localparam logic [31:0] Q30_ONE = 32'd1073741824;

   // Reciprocals for exact floor division of any 32-bit dividend.
   localparam logic [32:0] DIV_M110 = 33'(((65'd1 << 39) + 65'd109) / 65'd110);
   localparam logic [32:0] DIV_M72  = 33'(((65'd1 << 39) + 65'd71) / 65'd72);
   localparam logic [32:0] DIV_M42  = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
   localparam logic [32:0] DIV_M20  = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
   localparam logic [32:0] DIV_M9   = 33'(((65'd1 << 36) + 65'd8) / 65'd9);
   localparam logic [32:0] DIV_M8   = 33'(((65'd1 << 35) + 65'd7) / 65'd8);
   localparam logic [32:0] DIV_M7   = 33'(((65'd1 << 35) + 65'd6) / 65'd7);
   localparam logic [32:0] DIV_M6   = 33'(((65'd1 << 35) + 65'd5) / 65'd6);
   localparam logic [32:0] DIV_M5   = 33'(((65'd1 << 35) + 65'd4) / 65'd5);
   localparam logic [32:0] DIV_M4   = 33'(((65'd1 << 34) + 65'd3) / 65'd4);
   localparam logic [32:0] DIV_M3   = 33'(((65'd1 << 34) + 65'd2) / 65'd3);
   localparam logic [32:0] DIV_M2   = 33'(((65'd1 << 33) + 65'd1) / 65'd2);

   function automatic div_type div_magic(input logic [6:0] divisor);
      div_type r;
      case (divisor)
         7'd110: r = '{DIV_M110, 6'd39};
         7'd72:  r = '{DIV_M72, 6'd39};
         7'd42:  r = '{DIV_M42, 6'd38};
         7'd20:  r = '{DIV_M20, 6'd37};
         7'd9:   r = '{DIV_M9, 6'd36};
         7'd8:   r = '{DIV_M8, 6'd35};
         7'd7:   r = '{DIV_M7, 6'd35};
         7'd6:   r = '{DIV_M6, 6'd35};
         7'd5:   r = '{DIV_M5, 6'd35};
         7'd4:   r = '{DIV_M4, 6'd34};
         7'd3:   r = '{DIV_M3, 6'd34};
         default: r = '{DIV_M2, 6'd33};
      endcase
      return r;
   endfunction

   function automatic logic [6:0] sine_div(input logic [2:0] idx);
      logic [6:0] d;
      case (idx)
         3'd0: d = 7'd110;
         3'd1: d = 7'd72;
         3'd2: d = 7'd42;
         3'd3: d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/core/eca_mul.sv
module eca_mul (
   input  logic               clock,
   input  eca_pkg::mul_op_type op_a,
   input  eca_pkg::mul_op_type op_b,
   output eca_pkg::prod_type   product
);
   import eca_pkg::*;

   prod_type product_ff;
   prod_type product_in;

   assign product_in = prod_type'(op_a) * prod_type'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: rtl/core/easing_curve_animator.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_type, req_step_amount, req_time_value
// rsp       out        rsp_valid/rsp_stall  rsp_curve_value, rsp_current_time_out,
//                                           rsp_wrapped, rsp_moving_forward
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// The time from a request's transfer to the first cycle of its result depends on the
// curve, linear being the shortest and expo the longest; the shared multiplier registers
// its operands and its product, and the circ curve adds a 17-step square root loop.
// The request side stalls from the transfer until the result has been transferred, and
// the next request can be accepted in the cycle after that.
// Reset is synchronous and restores the configuration, the time and the direction flag.
module easing_curve_animator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  eca_pkg::step_type     req_step_amount,
   input  eca_pkg::time_type     req_time_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output eca_pkg::val_type      rsp_curve_value,
   output eca_pkg::time_type     rsp_current_time_out,
   output logic                  rsp_wrapped,
   output logic                  rsp_moving_forward,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  eca_pkg::csr_idx_type  csr_index,
   input  eca_pkg::csr_data_type csr_data
);
   import eca_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SUM, S_CMP, S_FIX, S_CURVE, S_POW, S_SIN_A, S_SIN_A2, S_SIN_M,
      S_SIN_D, S_SIN_S, S_EXP_Y, S_EXP_D, S_EXP_M, S_EXP_FIN, S_CIRC, S_SQRT,
      S_SCALE, S_ROUND, S_SUM_OUT, S_OUT
   } state_type;
   typedef logic signed [20:0] wide_time_type;
   typedef logic signed [22:0] curve_val_type;
   typedef logic signed [32:0] sum_type;

   curve_kind_type curve_ff, curve_in;
   logic [1:0]     loop_ff, loop_in;
   logic           dir_ff, dir_in;
   time_type       start_ff, start_in;
   time_type       end_ff, end_in;
   val_type        scale_ff, scale_in;
   val_type        shift_ff, shift_in;

   state_type      state_ff, state_in;
   logic           wait_ff, wait_in;
   req_kind_type   req_ff, req_in;
   step_type       step_ff, step_in;
   time_type       tv_ff, tv_in;
   wide_time_type  t1_ff, t1_in;
   logic           lt_ff, lt_in;
   logic           gt_ff, gt_in;
   time_type       cur_ff, cur_in;
   logic           gf_ff, gf_in;
   logic           wr_ff, wr_in;
   logic [31:0]    acc_a_ff, acc_a_in;
   logic [31:0]    acc_b_ff, acc_b_in;
   logic [31:0]    k_ff, k_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           neg_ff, neg_in;
   logic [1:0]     hi_ff, hi_in;
   logic [5:0]     div_sh_ff, div_sh_in;
   curve_val_type  cv_ff, cv_in;
   logic [33:0]    sq_n_ff, sq_n_in;
   logic [33:0]    sq_res_ff, sq_res_in;
   logic signed [31:0] rv_ff, rv_in;
   val_type        out_val_ff, out_val_in;
   mul_op_type     mul_a_ff, mul_a_in;
   mul_op_type     mul_b_ff, mul_b_in;

   prod_type          mul_prod;
   prod_type          p_rnd;
   logic [31:0]       p_hi;
   logic [PROD_W-1:0] q_full;
   logic [31:0]       div_q;

   function automatic mul_op_type zext32(input logic [31:0] v);
      return mul_op_type'({2'b00, v});
   endfunction

   function automatic prod_type rnd16(input prod_type v);
      prod_type bias;
      bias = v[PROD_W-1] ? prod_type'(32767) : prod_type'(32768);
      return (v + bias) >>> 16;
   endfunction

   function automatic time_type sat_time(input wide_time_type v);
      time_type r;
      if (v > wide_time_type'(131071)) begin
         r = time_type'(131071);
      end else if (v < wide_time_type'(-131072)) begin
         r = time_type'(-131072);
      end else begin
         r = v[TIME_W-1:0];
      end
      return r;
   endfunction

   eca_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .product (mul_prod)
   );

   assign p_rnd  = rnd16(mul_prod);
   assign p_hi   = mul_prod[61:30];
   assign q_full = mul_prod >> div_sh_ff;
   assign div_q  = q_full[31:0];

   always_comb begin
      curve_in = curve_ff;
      loop_in  = loop_ff;
      dir_in   = dir_ff;
      start_in = start_ff;
      end_in   = end_ff;
      scale_in = scale_ff;
      shift_in = shift_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CURVE: curve_in = curve_kind_type'(csr_data[2:0]);
            CSR_LOOP:  loop_in  = csr_data[1:0];
            CSR_DIR:   dir_in   = csr_data[0];
            CSR_START: start_in = csr_data[TIME_W-1:0];
            CSR_END:   end_in   = csr_data[TIME_W-1:0];
            CSR_SCALE: scale_in = csr_data;
            CSR_SHIFT: shift_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff <= CURVE_LINEAR;
         loop_ff  <= LOOP_CLAMP;
         dir_ff   <= 1'b0;
         start_ff <= '0;
         end_ff   <= time_type'(65536);
         scale_ff <= val_type'(65536);
         shift_ff <= '0;
      end else begin
         curve_ff <= curve_in;
         loop_ff  <= loop_in;
         dir_ff   <= dir_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         scale_ff <= scale_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      wide_time_type ws;
      wide_time_type we;
      wide_time_type t2;
      logic [16:0]   xs;
      div_type       dm;
      logic [31:0]   kv;
      logic [17:0]   s17;
      logic [32:0]   kr;
      prod_type      rr;
      logic [33:0]   sbit;
      logic [33:0]   ssum;
      logic [33:0]   sres;
      sum_type       vsum;

      state_in   = state_ff;
      wait_in    = 1'b0;
      req_in     = req_ff;
      step_in    = step_ff;
      tv_in      = tv_ff;
      t1_in      = t1_ff;
      lt_in      = lt_ff;
      gt_in      = gt_ff;
      cur_in     = cur_ff;
      gf_in      = gf_ff;
      wr_in      = wr_ff;
      acc_a_in   = acc_a_ff;
      acc_b_in   = acc_b_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      hi_in      = hi_ff;
      div_sh_in  = div_sh_ff;
      cv_in      = cv_ff;
      sq_n_in    = sq_n_ff;
      sq_res_in  = sq_res_ff;
      rv_in      = rv_ff;
      out_val_in = out_val_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;

      ws   = wide_time_type'(start_ff);
      we   = wide_time_type'(end_ff);
      t2   = t1_ff;
      xs   = '0;
      dm   = '0;
      kv   = '0;
      s17  = '0;
      kr   = '0;
      rr   = '0;
      sbit = '0;
      ssum = '0;
      sres = '0;
      vsum = '0;

      if (!wait_ff) begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_in   = req_kind_type'(req_type);
                  step_in  = req_step_amount;
                  tv_in    = req_time_value;
                  state_in = S_SUM;
               end
            end
            S_SUM: begin
               case (req_ff)
                  REQ_RESTART: t1_in = dir_ff ? we : ws;
                  REQ_ADVANCE: begin
                     if (gf_ff ^ dir_ff) begin
                        t1_in = wide_time_type'(cur_ff) + wide_time_type'(step_ff);
                     end else begin
                        t1_in = wide_time_type'(cur_ff) - wide_time_type'(step_ff);
                     end
                  end
                  REQ_SET: t1_in = wide_time_type'(tv_ff);
                  default: t1_in = wide_time_type'(cur_ff);
               endcase
               state_in = S_CMP;
            end
            S_CMP: begin
               lt_in    = t1_ff < ws;
               gt_in    = t1_ff > we;
               state_in = S_FIX;
            end
            S_FIX: begin
               wr_in = 1'b0;
               case (req_ff)
                  REQ_RESTART: gf_in = !dir_ff;
                  REQ_SET: begin
                     if (lt_ff) begin
                        t2 = ws;
                     end else if (gt_ff) begin
                        t2 = we;
                     end
                  end
                  REQ_ADVANCE: begin
                     if (lt_ff) begin
                        if (dir_ff) begin
                           if (loop_ff == LOOP_REWIND) begin
                              t2    = we - ws + t1_ff;
                              wr_in = 1'b1;
                           end else if (loop_ff == LOOP_PINGPONG) begin
                              t2    = (ws <<< 1) - t1_ff;
                              wr_in = 1'b1;
                              gf_in = 1'b0;
                           end else begin
                              t2 = ws;
                           end
                        end else begin
                           t2    = (ws <<< 1) - t1_ff;
                           wr_in = 1'b1;
                           gf_in = 1'b1;
                        end
                     end else if (gt_ff) begin
                        if (!dir_ff) begin
                           if (loop_ff == LOOP_REWIND) begin
                              t2    = ws + t1_ff - we;
                              wr_in = 1'b1;
                           end else if (loop_ff == LOOP_PINGPONG) begin
                              t2    = (we <<< 1) - t1_ff;
                              wr_in = 1'b1;
                              gf_in = 1'b0;
                           end else begin
                              t2 = we;
                           end
                        end else begin
                           t2    = (we <<< 1) - t1_ff;
                           wr_in = 1'b1;
                           gf_in = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
               cur_in   = sat_time(t2);
               state_in = S_CURVE;
            end
            S_CURVE: begin
               case (curve_ff)
                  CURVE_LINEAR: begin
                     cv_in    = curve_val_type'(cur_ff);
                     state_in = S_SCALE;
                  end
                  CURVE_SINE: begin
                     neg_in = cur_ff[16];
                     xs     = {1'b0, cur_ff[15:0]};
                     if (xs > 17'd32768) begin
                        xs = 17'd65536 - xs;
                     end
                     mul_a_in = mul_op_type'({xs, 14'd0});
                     mul_b_in = zext32(PI_Q30);
                     wait_in  = 1'b1;
                     state_in = S_SIN_A;
                  end
                  CURVE_EXPO: begin
                     hi_in    = {~cur_ff[17], cur_ff[16]};
                     mul_a_in = mul_op_type'({cur_ff[15:0], 14'd0});
                     mul_b_in = zext32(LN2_Q30);
                     wait_in  = 1'b1;
                     state_in = S_EXP_Y;
                  end
                  CURVE_CIRC: begin
                     mul_a_in = mul_op_type'(cur_ff);
                     mul_b_in = mul_op_type'(cur_ff);
                     wait_in  = 1'b1;
                     state_in = S_CIRC;
                  end
                  default: begin
                     mul_a_in = mul_op_type'(cur_ff);
                     mul_b_in = mul_op_type'(cur_ff);
                     cnt_in   = {2'b00, curve_ff};
                     wait_in  = 1'b1;
                     state_in = S_POW;
                  end
               endcase
            end
            S_POW: begin
               if (cnt_ff == 5'd1) begin
                  cv_in    = p_rnd[22:0];
                  state_in = S_SCALE;
               end else begin
                  mul_a_in = p_rnd[MUL_W-1:0];
                  mul_b_in = mul_op_type'(cur_ff);
                  cnt_in   = cnt_ff - 5'd1;
                  wait_in  = 1'b1;
               end
            end
            S_SIN_A: begin
               acc_a_in = p_hi;
               mul_a_in = zext32(p_hi);
               mul_b_in = zext32(p_hi);
               wait_in  = 1'b1;
               state_in = S_SIN_A2;
            end
            S_SIN_A2: begin
               acc_b_in = p_hi;
               mul_a_in = zext32(p_hi);
               mul_b_in = zext32(Q30_ONE);
               cnt_in   = '0;
               wait_in  = 1'b1;
               state_in = S_SIN_M;
            end
            S_SIN_M: begin
               dm        = div_magic(sine_div(cnt_ff[2:0]));
               div_sh_in = dm.shift;
               mul_a_in  = zext32(p_hi);
               mul_b_in  = mul_op_type'({1'b0, dm.magic});
               wait_in   = 1'b1;
               state_in  = S_SIN_D;
            end
            S_SIN_D: begin
               kv       = Q30_ONE - div_q;
               k_in     = kv;
               mul_b_in = zext32(kv);
               wait_in  = 1'b1;
               if (cnt_ff == 5'd4) begin
                  mul_a_in = zext32(acc_a_ff);
                  state_in = S_SIN_S;
               end else begin
                  mul_a_in = zext32(acc_b_ff);
                  cnt_in   = cnt_ff + 5'd1;
                  state_in = S_SIN_M;
               end
            end
            S_SIN_S: begin
               kv  = (p_hi + 32'd8192) >> 14;
               s17 = kv[17:0];
               if (neg_ff) begin
                  cv_in = -curve_val_type'(s17);
               end else begin
                  cv_in = curve_val_type'(s17);
               end
               state_in = S_SCALE;
            end
            S_EXP_Y: begin
               dm        = div_magic(7'd9);
               div_sh_in = dm.shift;
               acc_a_in  = p_hi;
               mul_a_in  = zext32(p_hi);
               mul_b_in  = mul_op_type'({1'b0, dm.magic});
               cnt_in    = 5'd9;
               wait_in   = 1'b1;
               state_in  = S_EXP_D;
            end
            S_EXP_D: begin
               kv       = Q30_ONE + div_q;
               k_in     = kv;
               mul_a_in = zext32(acc_a_ff);
               mul_b_in = zext32(kv);
               cnt_in   = cnt_ff - 5'd1;
               wait_in  = 1'b1;
               state_in = S_EXP_M;
            end
            S_EXP_M: begin
               if (cnt_ff == 5'd1) begin
                  k_in     = Q30_ONE + p_hi;
                  state_in = S_EXP_FIN;
               end else begin
                  dm        = div_magic({2'b00, cnt_ff});
                  div_sh_in = dm.shift;
                  mul_a_in  = zext32(p_hi);
                  mul_b_in  = mul_op_type'({1'b0, dm.magic});
                  wait_in   = 1'b1;
                  state_in  = S_EXP_D;
               end
            end
            S_EXP_FIN: begin
               case (hi_ff)
                  2'd0:    kr = ({1'b0, k_ff} + 33'd32768) >> 16;
                  2'd1:    kr = ({1'b0, k_ff} + 33'd16384) >> 15;
                  2'd2:    kr = ({1'b0, k_ff} + 33'd8192) >> 14;
                  default: kr = ({1'b0, k_ff} + 33'd4096) >> 13;
               endcase
               cv_in    = curve_val_type'(65536) - curve_val_type'(kr[21:0]);
               state_in = S_SCALE;
            end
            S_CIRC: begin
               rr = prod_type'(65536) - p_rnd;
               if (rr < 0) begin
                  rr = '0;
               end
               sq_n_in   = {rr[17:0], 16'd0};
               sq_res_in = '0;
               cnt_in    = 5'd16;
               state_in  = S_SQRT;
            end
            S_SQRT: begin
               sbit = 34'd1 << {cnt_ff, 1'b0};
               ssum = sq_res_ff + sbit;
               if (sq_n_ff >= ssum) begin
                  sq_n_in = sq_n_ff - ssum;
                  sres    = (sq_res_ff >> 1) + sbit;
               end else begin
                  sres = sq_res_ff >> 1;
               end
               sq_res_in = sres;
               if (cnt_ff == 5'd0) begin
                  cv_in    = sres[22:0];
                  state_in = S_SCALE;
               end else begin
                  cnt_in = cnt_ff - 5'd1;
               end
            end
            S_SCALE: begin
               mul_a_in = mul_op_type'(cv_ff);
               mul_b_in = mul_op_type'(scale_ff);
               wait_in  = 1'b1;
               state_in = S_ROUND;
            end
            S_ROUND: begin
               rv_in    = p_rnd[31:0];
               state_in = S_SUM_OUT;
            end
            S_SUM_OUT: begin
               vsum = sum_type'(rv_ff) + sum_type'(shift_ff);
               if (vsum > sum_type'(8388607)) begin
                  out_val_in = val_type'(8388607);
               end else if (vsum < sum_type'(-8388608)) begin
                  out_val_in = val_type'(-8388608);
               end else begin
                  out_val_in = vsum[VAL_W-1:0];
               end
               state_in = S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_in = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
         cur_ff   <= '0;
         gf_ff    <= 1'b1;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         cur_ff   <= cur_in;
         gf_ff    <= gf_in;
      end
      req_ff     <= req_in;
      step_ff    <= step_in;
      tv_ff      <= tv_in;
      t1_ff      <= t1_in;
      lt_ff      <= lt_in;
      gt_ff      <= gt_in;
      wr_ff      <= wr_in;
      acc_a_ff   <= acc_a_in;
      acc_b_ff   <= acc_b_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      hi_ff      <= hi_in;
      div_sh_ff  <= div_sh_in;
      cv_ff      <= cv_in;
      sq_n_ff    <= sq_n_in;
      sq_res_ff  <= sq_res_in;
      rv_ff      <= rv_in;
      out_val_ff <= out_val_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_curve_value      = out_val_ff;
   assign rsp_current_time_out = cur_ff;
   assign rsp_wrapped          = wr_ff;
   assign rsp_moving_forward   = gf_ff;
   assign csr_ready            = 1'b1;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_SUM)
      else $error("Accepted request did not start the time update.");

   a_wrap_only_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wrapped |-> req_ff == REQ_ADVANCE)
      else $error("Wrap flagged on a request that is not an advance.");

   a_restart_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_ff == REQ_RESTART |-> rsp_moving_forward == !dir_ff)
      else $error("Restart left the wrong direction flag.");

   a_set_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_ff == REQ_SET && start_ff <= end_ff
      |-> rsp_current_time_out >= start_ff && rsp_current_time_out <= end_ff)
      else $error("Set time result lies outside the bounds.");

   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQRT |-> cnt_ff <= 5'd16)
      else $error("Square root step count out of range.");

endmodule
